[src/pom_pkg.sv]
// Shared types, constants and register codes for the perturb-and-observe MPPT block.
`timescale 1ns / 1ps

package pom_pkg;

    localparam int CFG_DUTY_W   = 10;
    localparam int STEP_W       = 6;
    localparam int COR_W        = 8;
    localparam int CUR_W        = 11;
    localparam int MV_W         = 15;
    localparam int POWER_W      = 26;
    localparam int CFG_DATA_W   = 15;
    localparam int CFG_IDX_W    = 3;

    localparam int DUTY_BITS_DEF = 10;
    localparam int DUTY_RESET    = 350;
    localparam int DEADBAND_UW   = 10000;

    localparam logic [CFG_DUTY_W-1:0] MIN_DUTY_RST = CFG_DUTY_W'(100);
    localparam logic [CFG_DUTY_W-1:0] MAX_DUTY_RST = CFG_DUTY_W'(600);
    localparam logic [STEP_W-1:0]     STEP_RST     = STEP_W'(2);
    localparam logic [COR_W-1:0]      COR_RST      = COR_W'(10);
    localparam logic [CUR_W-1:0]      MAX_CUR_RST  = CUR_W'(1000);
    localparam logic [MV_W-1:0]       MAX_VOUT_RST = MV_W'(29000);
    localparam logic [MV_W-1:0]       NUDGE_VOUT_RST = MV_W'(26000);
    localparam logic [MV_W-1:0]       NUDGE_VIN_RST  = MV_W'(15000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DUTY   = 3'd0,
        CFG_MAX_DUTY   = 3'd1,
        CFG_STEP_SIZE  = 3'd2,
        CFG_CORRECTION = 3'd3,
        CFG_MAX_CUR    = 3'd4,
        CFG_MAX_VOUT   = 3'd5,
        CFG_NUDGE_VOUT = 3'd6,
        CFG_NUDGE_VIN  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_DUTY_W-1:0] min_duty;
        logic [CFG_DUTY_W-1:0] max_duty;
        logic [STEP_W-1:0]     step_size;
        logic [COR_W-1:0]      correction;
        logic [CUR_W-1:0]      max_current_ma;
        logic [MV_W-1:0]       max_vout_mv;
        logic [MV_W-1:0]       nudge_vout_mv;
        logic [MV_W-1:0]       nudge_vin_mv;
    } t_cfg;

    typedef struct packed {
        logic [CUR_W-1:0]   current_ma;
        logic [MV_W-1:0]    vin_mv;
        logic [MV_W-1:0]    vout_mv;
        logic [POWER_W-1:0] power_uw;
    } t_meas;

endpackage

[src/pom_cfg.sv]
// Configuration register file for the MPPT block.
`timescale 1ns / 1ps

module pom_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pom_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pom_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output pom_pkg::t_cfg                   o_cfg
);
    import pom_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MIN_DUTY:   n_cfg.min_duty       = i_cfg_data[CFG_DUTY_W-1:0];
                CFG_MAX_DUTY:   n_cfg.max_duty       = i_cfg_data[CFG_DUTY_W-1:0];
                CFG_STEP_SIZE:  n_cfg.step_size      = i_cfg_data[STEP_W-1:0];
                CFG_CORRECTION: n_cfg.correction     = i_cfg_data[COR_W-1:0];
                CFG_MAX_CUR:    n_cfg.max_current_ma = i_cfg_data[CUR_W-1:0];
                CFG_MAX_VOUT:   n_cfg.max_vout_mv    = i_cfg_data[MV_W-1:0];
                CFG_NUDGE_VOUT: n_cfg.nudge_vout_mv  = i_cfg_data[MV_W-1:0];
                CFG_NUDGE_VIN:  n_cfg.nudge_vin_mv   = i_cfg_data[MV_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_duty       <= MIN_DUTY_RST;
            r_cfg.max_duty       <= MAX_DUTY_RST;
            r_cfg.step_size      <= STEP_RST;
            r_cfg.correction     <= COR_RST;
            r_cfg.max_current_ma <= MAX_CUR_RST;
            r_cfg.max_vout_mv    <= MAX_VOUT_RST;
            r_cfg.nudge_vout_mv  <= NUDGE_VOUT_RST;
            r_cfg.nudge_vin_mv   <= NUDGE_VIN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/pom_power.sv]
// Input register and power multiply stage.
`timescale 1ns / 1ps

module pom_power (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [pom_pkg::CUR_W-1:0]   i_current_ma,
    input  logic [pom_pkg::MV_W-1:0]    i_vin_mv,
    input  logic [pom_pkg::MV_W-1:0]    i_vout_mv,
    output logic                        o_pwr_valid,
    input  logic                        i_pwr_ready,
    output pom_pkg::t_meas              o_meas
);
    import pom_pkg::*;

    logic             r_in_valid;
    logic [CUR_W-1:0] r_cur;
    logic [MV_W-1:0]  r_vin;
    logic [MV_W-1:0]  r_vout;
    logic             r_m_valid;
    t_meas            r_meas;
    logic             m_ready;
    logic             in_ready;

    assign m_ready  = !r_m_valid || i_pwr_ready;
    assign in_ready = !r_in_valid || m_ready;
    assign o_stall  = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_valid;
            end
            if (m_ready) begin
                r_m_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_cur  <= i_current_ma;
            r_vin  <= i_vin_mv;
            r_vout <= i_vout_mv;
        end
        if (m_ready && r_in_valid) begin
            r_meas.current_ma <= r_cur;
            r_meas.vin_mv     <= r_vin;
            r_meas.vout_mv    <= r_vout;
            // 11 x 15 bit product always fits in 26 bits
            r_meas.power_uw   <= POWER_W'(r_cur) * POWER_W'(r_vin);
        end
    end

    assign o_pwr_valid = r_m_valid;
    assign o_meas      = r_meas;

endmodule

[src/pom_track.sv]
// Perturb-and-observe duty update, tracking state and result register.
`timescale 1ns / 1ps

module pom_track #(
    parameter int DUTY_BITS = pom_pkg::DUTY_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pom_pkg::t_cfg                i_cfg,
    input  logic                         i_pwr_valid,
    output logic                         o_pwr_ready,
    input  pom_pkg::t_meas               i_meas,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [DUTY_BITS-1:0]         o_duty,
    output logic [pom_pkg::POWER_W-1:0]  o_power_uw,
    output logic                         o_duty_too_high,
    output logic                         o_duty_too_low
);
    import pom_pkg::*;

    localparam int DUTY_LIMIT = (1 << DUTY_BITS) - 1;
    localparam int DUTY_INIT  = (DUTY_RESET > DUTY_LIMIT) ? DUTY_LIMIT : DUTY_RESET;
    // signed working width: covers the larger of duty and bound range plus corrections
    localparam int DW = ((DUTY_BITS > CFG_DUTY_W) ? DUTY_BITS : CFG_DUTY_W) + 2;

    logic [DUTY_BITS-1:0] r_duty;
    logic [POWER_W-1:0]   r_prev_power;
    logic [MV_W-1:0]      r_prev_vin;
    logic                 r_o_valid;
    logic [DUTY_BITS-1:0] r_o_duty;
    logic [POWER_W-1:0]   r_o_power;
    logic                 r_o_high;
    logic                 r_o_low;

    logic                 out_ready;
    logic                 fire;
    logic signed [DW-1:0] d_cur, d_trk, d_ov, d_fix, lo, hi, st, cor, lim;
    logic [DUTY_BITS-1:0] n_duty;
    logic                 n_high, n_low;
    logic                 ov_volt, ov_cur, p_up, p_down, v_up, v_down, nudge;

    assign out_ready   = !r_o_valid || !i_stall;
    assign o_pwr_ready = out_ready;
    assign fire        = i_pwr_valid && out_ready;

    always_comb begin
        d_cur = $signed(DW'(r_duty));
        lo    = $signed(DW'(i_cfg.min_duty));
        hi    = $signed(DW'(i_cfg.max_duty));
        st    = $signed(DW'(i_cfg.step_size));
        cor   = $signed(DW'(i_cfg.correction));
        lim   = $signed(DW'(DUTY_LIMIT));

        ov_volt = i_meas.vout_mv > i_cfg.max_vout_mv;
        ov_cur  = i_meas.current_ma > i_cfg.max_current_ma;
        // deadband tests in one extra bit so the offset add cannot wrap
        p_up    = {1'b0, i_meas.power_uw} > ({1'b0, r_prev_power} + (POWER_W + 1)'(DEADBAND_UW));
        p_down  = {1'b0, r_prev_power} > ({1'b0, i_meas.power_uw} + (POWER_W + 1)'(DEADBAND_UW));
        v_up    = i_meas.vin_mv > r_prev_vin;
        v_down  = i_meas.vin_mv < r_prev_vin;
        nudge   = (i_meas.vout_mv < i_cfg.nudge_vout_mv) && (i_meas.vin_mv > i_cfg.nudge_vin_mv);

        d_trk = d_cur;
        if (d_cur < hi && d_cur > lo) begin
            if (ov_volt || ov_cur) begin
                d_trk = d_cur - cor;
            end else if (p_up) begin
                if (v_up) begin
                    d_trk = d_cur + st;
                end else if (v_down) begin
                    d_trk = d_cur - st;
                end
            end else if (p_down) begin
                if (v_up) begin
                    d_trk = d_cur - st;
                end else if (v_down) begin
                    d_trk = d_cur + st;
                end
            end else if (nudge) begin
                d_trk = d_cur + st;
            end
        end else if (d_cur == hi) begin
            d_trk = d_cur - st;
        end else if (d_cur == lo) begin
            d_trk = d_cur + st;
        end

        // safety pass
        d_ov = ov_volt ? (d_trk - cor) : d_trk;
        n_high = 1'b0;
        n_low  = 1'b0;
        d_fix  = d_ov;
        if (d_ov > hi) begin
            d_fix  = d_ov - cor;
            n_high = 1'b1;
        end else if (d_ov < lo) begin
            d_fix  = d_ov + cor;
            n_low  = 1'b1;
        end

        if (d_fix < $signed(DW'(0))) begin
            n_duty = '0;
        end else if (d_fix > lim) begin
            n_duty = DUTY_BITS'(DUTY_LIMIT);
        end else begin
            n_duty = d_fix[DUTY_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty       <= DUTY_BITS'(DUTY_INIT);
            r_prev_power <= '0;
            r_prev_vin   <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (out_ready) begin
                r_o_valid <= i_pwr_valid;
            end
            if (fire) begin
                r_duty       <= n_duty;
                r_prev_power <= i_meas.power_uw;
                r_prev_vin   <= i_meas.vin_mv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_o_duty  <= n_duty;
            r_o_power <= i_meas.power_uw;
            r_o_high  <= n_high;
            r_o_low   <= n_low;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_duty          = r_o_duty;
    assign o_power_uw      = r_o_power;
    assign o_duty_too_high = r_o_high;
    assign o_duty_too_low  = r_o_low;

endmodule

[src/perturb_observe_mppt.sv]
// Perturb-and-observe MPPT top level: config registers, power stage, duty tracker.
// An accepted request moves through the input reg, multiply reg and result reg into o_valid.
// Throughput: one request per cycle unless stalled; duty/prev-sample state closes in last stage.
// Reset (synchronous, active low): pipeline empty, duty = 350 clamped to the duty range,
// previous power and vin = 0, config registers at their defaults.
`timescale 1ns / 1ps

module perturb_observe_mppt #(
    parameter int DUTY_BITS = pom_pkg::DUTY_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pom_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pom_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [pom_pkg::CUR_W-1:0]       i_current_ma,
    input  logic [pom_pkg::MV_W-1:0]        i_vin_mv,
    input  logic [pom_pkg::MV_W-1:0]        i_vout_mv,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [DUTY_BITS-1:0]            o_duty,
    output logic [pom_pkg::POWER_W-1:0]     o_power_uw,
    output logic                            o_duty_too_high,
    output logic                            o_duty_too_low
);
    import pom_pkg::*;

    t_cfg  w_cfg;
    t_meas w_meas;
    logic  w_pwr_valid;
    logic  w_pwr_ready;

    pom_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    pom_power u_power (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_current_ma (i_current_ma),
        .i_vin_mv     (i_vin_mv),
        .i_vout_mv    (i_vout_mv),
        .o_pwr_valid  (w_pwr_valid),
        .i_pwr_ready  (w_pwr_ready),
        .o_meas       (w_meas)
    );

    pom_track #(
        .DUTY_BITS (DUTY_BITS)
    ) u_track (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_pwr_valid     (w_pwr_valid),
        .o_pwr_ready     (w_pwr_ready),
        .i_meas          (w_meas),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_duty          (o_duty),
        .o_power_uw      (o_power_uw),
        .o_duty_too_high (o_duty_too_high),
        .o_duty_too_low  (o_duty_too_low)
    );

    // input side only backs up when every stage downstream is full and blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (w_pwr_valid && o_valid && i_stall))
        else $error("input stalled with room in the pipeline");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_duty_too_high && o_duty_too_low))
        else $error("duty flagged both high and low");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_pwr_valid))
        else $error("result appeared without a request in the power stage");

    a_ready_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pwr_valid && !w_pwr_ready) |-> (o_valid && i_stall))
        else $error("power stage held back while result register could take it");

endmodule
